>>> rtl/gaussian_point_frame_transform_unit_assert.svh
// assertion macros shared by the frame transform checkers
`ifndef GAUSSIAN_POINT_FRAME_TRANSFORM_UNIT_ASSERT_SVH
`define GAUSSIAN_POINT_FRAME_TRANSFORM_UNIT_ASSERT_SVH

// same-cycle implication
`define GPFT_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("gpft: assertion failed");

// next-cycle implication
`define GPFT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("gpft: assertion failed");

`endif

>>> rtl/gpft_pkg.sv
// types and constants of the gaussian point frame transform unit
`default_nettype none

package gpft_pkg;

    localparam int WORDS_PER_FRAME = 8;
    localparam int WORD_W          = 32;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_XFORM = 1'b1;

    typedef struct packed {
        logic               func;
        logic [6:0]         entry_addr;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic signed [31:0] size_x;
        logic signed [31:0] size_y;
        logic signed [31:0] size_z;
    } req_t;

    typedef struct packed {
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] out_quat_w;
        logic signed [31:0] out_quat_x;
        logic signed [31:0] out_quat_y;
        logic signed [31:0] out_quat_z;
        logic signed [31:0] out_size_x;
        logic signed [31:0] out_size_y;
        logic signed [31:0] out_size_z;
        logic               bad_frame;
    } rsp_t;

endpackage

`default_nettype wire

>>> rtl/gaussian_point_frame_transform_unit.sv
// Gaussian point frame transform unit: applies per-frame similarity transforms to points.
//
// One input channel (req_valid / req_ready / req) carries two kinds of transaction.
// A load (func = 0) writes one 32-bit word of the frame table at entry_addr = frame*8+word
// and gives no result; loads beyond the table are dropped. A transform (func = 1) names a
// frame in entry_addr and gives one result on rsp_valid / rsp_ready / rsp: position
// t + R(q)(s*p), orientation q*p_quat, sizes s*size, all Q16.16 with saturation. A frame
// index out of range returns the point unchanged with bad_frame set.
// One transaction is taken every cycle unless a stalled receiver has filled the pipeline.
// A transform passes through the frame table read, first products, matrix and quaternion
// sums and rotation products, with the position sum formed as the output register loads.
// A load occupies only the read-modify-write stage;
// the frame table is one row per frame, and a load to the row just written is forwarded.
// After reset every frame is the identity with scale one; per-row valid bits stand in for
// the table contents until a row is first written, so no clearing pass is needed.
// When the receiver stalls, results fill the pipeline stages and req_ready drops only once
// every stage holds a transform.
`default_nettype none

module gaussian_point_frame_transform_unit #(
    parameter int NUM_FRAMES = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  gpft_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output gpft_pkg::rsp_t rsp
);

    localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int ROW_W = gpft_pkg::WORDS_PER_FRAME * gpft_pkg::WORD_W;
    localparam logic [31:0] ONE = 32'(1 << FRAC_BITS);
    localparam logic [ROW_W-1:0] IDENT_ROW = {ONE, ONE, {(ROW_W - 64){1'b0}}};
    localparam logic signed [63:0] RND   = 64'sh1 << (FRAC_BITS - 1);
    localparam logic signed [63:0] ONE64 = 64'sh1 << FRAC_BITS;

    // rotation product slots
    localparam int XX = 0, YY = 1, ZZ = 2, XY = 3, XZ = 4, YZ = 5, XW = 6, YW = 7, ZW = 8;

    function automatic logic signed [63:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] p;
        p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        return (p + RND) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -64'sh0000_0000_8000_0000)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // ---------------- accept and table read ----------------
    logic [7:0]       fr;
    logic             in_rng;
    logic             acc;
    logic [IDX_W-1:0] raddr;

    assign fr     = (req.func == gpft_pkg::FUNC_XFORM) ? {1'b0, req.entry_addr}
                                                     : {4'b0, req.entry_addr[6:3]};
    assign in_rng = ({1'b0, fr} < 9'(NUM_FRAMES));
    assign acc    = req_valid && req_ready;
    assign raddr  = IDX_W'(fr);

    logic             v1_reg, v2_reg, v3_reg, v4_reg, rsp_valid_reg;
    logic             lv1, rdy2, rdy3, rdy4, rdy_out;
    gpft_pkg::req_t   pl1_reg;
    logic             rng1_reg, hit1_reg, vld1_reg;
    logic [IDX_W-1:0] idx1_reg;
    logic [ROW_W-1:0] fwd_row_reg;
    logic [ROW_W-1:0] ram_q, row1, row_new;
    logic             we;
    logic [NUM_FRAMES-1:0] row_vld_reg;
    logic             is_load1;

    assign is_load1 = (pl1_reg.func == gpft_pkg::FUNC_LOAD);
    assign row1     = hit1_reg ? fwd_row_reg : (vld1_reg ? ram_q : IDENT_ROW);

    always_comb
    begin
        row_new = row1;
        row_new[{pl1_reg.entry_addr[2:0], 5'b0} +: 32] = pl1_reg.pos_x;
    end

    assign we = v1_reg && is_load1 && rng1_reg;

    gpft_ram #(
        .WIDTH(ROW_W),
        .DEPTH(NUM_FRAMES)
    ) u_frame_ram (
        .clk  (clk),
        .we   (we),
        .waddr(idx1_reg),
        .wdata(row_new),
        .re   (acc),
        .raddr(raddr),
        .rdata(ram_q)
    );

    // handshake chain
    assign rdy_out   = !rsp_valid_reg || rsp_ready;
    assign rdy4      = !v4_reg || rdy_out;
    assign rdy3      = !v3_reg || rdy4;
    assign rdy2      = !v2_reg || rdy3;
    assign lv1       = v1_reg && (is_load1 || rdy2);
    assign req_ready = !v1_reg || lv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
            row_vld_reg   <= '0;
        end
        else
        begin
            if (req_ready)
            begin
                v1_reg <= req_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg && !is_load1;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy_out)
            begin
                rsp_valid_reg <= v4_reg;
            end
            if (we)
            begin
                row_vld_reg[idx1_reg] <= 1'b1;
            end
        end
    end

    // a write landing on the row read in the same cycle is forwarded
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            pl1_reg     <= req;
            rng1_reg    <= in_rng;
            idx1_reg    <= raddr;
            hit1_reg    <= we && (idx1_reg == raddr);
            fwd_row_reg <= row_new;
            vld1_reg    <= in_rng && row_vld_reg[raddr];
        end
    end

    // ---------------- stage 2: first products ----------------
    logic signed [31:0] qv [4];
    logic signed [31:0] pv [4];
    logic signed [31:0] pp [3];
    logic signed [31:0] sz [3];
    logic signed [31:0] fs;
    logic signed [63:0] qq_next  [9];
    logic signed [63:0] spp_next [3];
    logic signed [63:0] qp_next  [16];
    logic signed [63:0] szp_next [3];

    always_comb
    begin
        qv[0] = row1[6*32 +: 32];
        qv[1] = row1[3*32 +: 32];
        qv[2] = row1[4*32 +: 32];
        qv[3] = row1[5*32 +: 32];
        fs    = row1[7*32 +: 32];
        pv[0] = pl1_reg.quat_w;
        pv[1] = pl1_reg.quat_x;
        pv[2] = pl1_reg.quat_y;
        pv[3] = pl1_reg.quat_z;
        pp[0] = pl1_reg.pos_x;
        pp[1] = pl1_reg.pos_y;
        pp[2] = pl1_reg.pos_z;
        sz[0] = pl1_reg.size_x;
        sz[1] = pl1_reg.size_y;
        sz[2] = pl1_reg.size_z;
        qq_next[XX] = fx_mul(qv[1], qv[1]);
        qq_next[YY] = fx_mul(qv[2], qv[2]);
        qq_next[ZZ] = fx_mul(qv[3], qv[3]);
        qq_next[XY] = fx_mul(qv[1], qv[2]);
        qq_next[XZ] = fx_mul(qv[1], qv[3]);
        qq_next[YZ] = fx_mul(qv[2], qv[3]);
        qq_next[XW] = fx_mul(qv[1], qv[0]);
        qq_next[YW] = fx_mul(qv[2], qv[0]);
        qq_next[ZW] = fx_mul(qv[3], qv[0]);
        for (int i = 0; i < 3; i++)
        begin
            spp_next[i] = fx_mul(fs, pp[i]);
            szp_next[i] = fx_mul(sz[i], fs);
        end
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                qp_next[i*4 + j] = fx_mul(qv[i], pv[j]);
            end
        end
    end

    logic signed [63:0] qq_reg  [9];
    logic signed [63:0] spp_reg [3];
    logic signed [63:0] qp_reg  [16];
    logic signed [63:0] szp_reg [3];
    logic [95:0]        t2_reg, t3_reg, t4_reg;
    gpft_pkg::req_t     pl2_reg, pl3_reg, pl4_reg;
    logic               bad2_reg, bad3_reg, bad4_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            qq_reg   <= qq_next;
            spp_reg  <= spp_next;
            qp_reg   <= qp_next;
            szp_reg  <= szp_next;
            t2_reg   <= row1[95:0];
            pl2_reg  <= pl1_reg;
            bad2_reg <= !rng1_reg;
        end
    end

    // ---------------- stage 3: matrix, saturations, quaternion sums ----------------
    logic signed [31:0] m_next  [9];
    logic signed [31:0] sp_next [3];
    logic signed [31:0] qo_next [4];
    logic signed [31:0] so_next [3];

    always_comb
    begin
        m_next[0] = sat32(ONE64 - ((qq_reg[YY] + qq_reg[ZZ]) <<< 1));
        m_next[1] = sat32((qq_reg[XY] - qq_reg[ZW]) <<< 1);
        m_next[2] = sat32((qq_reg[XZ] + qq_reg[YW]) <<< 1);
        m_next[3] = sat32((qq_reg[XY] + qq_reg[ZW]) <<< 1);
        m_next[4] = sat32(ONE64 - ((qq_reg[XX] + qq_reg[ZZ]) <<< 1));
        m_next[5] = sat32((qq_reg[YZ] - qq_reg[XW]) <<< 1);
        m_next[6] = sat32((qq_reg[XZ] - qq_reg[YW]) <<< 1);
        m_next[7] = sat32((qq_reg[YZ] + qq_reg[XW]) <<< 1);
        m_next[8] = sat32(ONE64 - ((qq_reg[XX] + qq_reg[YY]) <<< 1));
        for (int i = 0; i < 3; i++)
        begin
            sp_next[i] = sat32(spp_reg[i]);
            so_next[i] = sat32(szp_reg[i]);
        end
        // hamilton product, frame quaternion on the left, order w x y z
        qo_next[0] = sat32(qp_reg[0] - qp_reg[5] - qp_reg[10] - qp_reg[15]);
        qo_next[1] = sat32(qp_reg[1] + qp_reg[4] + qp_reg[11] - qp_reg[14]);
        qo_next[2] = sat32(qp_reg[2] - qp_reg[7] + qp_reg[8] + qp_reg[13]);
        qo_next[3] = sat32(qp_reg[3] + qp_reg[6] - qp_reg[9] + qp_reg[12]);
    end

    logic signed [31:0] m_reg   [9];
    logic signed [31:0] sp_reg  [3];
    logic signed [31:0] qo3_reg [4];
    logic signed [31:0] so3_reg [3];

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            m_reg    <= m_next;
            sp_reg   <= sp_next;
            qo3_reg  <= qo_next;
            so3_reg  <= so_next;
            t3_reg   <= t2_reg;
            pl3_reg  <= pl2_reg;
            bad3_reg <= bad2_reg;
        end
    end

    // ---------------- stage 4: rotation products ----------------
    logic signed [63:0] mp_next [9];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                mp_next[r*3 + c] = fx_mul(m_reg[r*3 + c], sp_reg[c]);
            end
        end
    end

    logic signed [63:0] mp_reg  [9];
    logic signed [31:0] qo4_reg [4];
    logic signed [31:0] so4_reg [3];

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            mp_reg   <= mp_next;
            qo4_reg  <= qo3_reg;
            so4_reg  <= so3_reg;
            t4_reg   <= t3_reg;
            pl4_reg  <= pl3_reg;
            bad4_reg <= bad3_reg;
        end
    end

    // ---------------- output: translation sum and pass-through ----------------
    logic signed [31:0] pos_next [3];
    logic signed [31:0] tw;
    gpft_pkg::rsp_t     rsp_next;
    gpft_pkg::rsp_t     rsp_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            tw = t4_reg[r*32 +: 32];
            pos_next[r] = sat32($signed({{32{tw[31]}}, tw}) + mp_reg[r*3] + mp_reg[r*3 + 1]
                                + mp_reg[r*3 + 2]);
        end
        if (bad4_reg)
        begin
            rsp_next.out_pos_x  = pl4_reg.pos_x;
            rsp_next.out_pos_y  = pl4_reg.pos_y;
            rsp_next.out_pos_z  = pl4_reg.pos_z;
            rsp_next.out_quat_w = pl4_reg.quat_w;
            rsp_next.out_quat_x = pl4_reg.quat_x;
            rsp_next.out_quat_y = pl4_reg.quat_y;
            rsp_next.out_quat_z = pl4_reg.quat_z;
            rsp_next.out_size_x = pl4_reg.size_x;
            rsp_next.out_size_y = pl4_reg.size_y;
            rsp_next.out_size_z = pl4_reg.size_z;
            rsp_next.bad_frame  = 1'b1;
        end
        else
        begin
            rsp_next.out_pos_x  = pos_next[0];
            rsp_next.out_pos_y  = pos_next[1];
            rsp_next.out_pos_z  = pos_next[2];
            rsp_next.out_quat_w = qo4_reg[0];
            rsp_next.out_quat_x = qo4_reg[1];
            rsp_next.out_quat_y = qo4_reg[2];
            rsp_next.out_quat_z = qo4_reg[3];
            rsp_next.out_size_x = so4_reg[0];
            rsp_next.out_size_y = so4_reg[1];
            rsp_next.out_size_z = so4_reg[2];
            rsp_next.bad_frame  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_out && v4_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

>>> rtl/gpft_ram.sv
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module gpft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first: a read of the entry being written returns the old data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

`default_nettype wire

>>> rtl/gpft_checker.sv
// port-level checker for the frame transform unit, bound to the top level
`default_nettype none

`include "gaussian_point_frame_transform_unit_assert.svh"

module gpft_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input gpft_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input gpft_pkg::rsp_t rsp
);

    // consecutive cycles with no input offered and the receiver ready
    logic [2:0] quiet_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cnt_reg <= 3'd0;
        end
        else if (req_valid || !rsp_ready)
        begin
            quiet_cnt_reg <= 3'd0;
        end
        else if (quiet_cnt_reg != 3'd5)
        begin
            quiet_cnt_reg <= quiet_cnt_reg + 3'd1;
        end
    end

    // a stalled result holds
    `GPFT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // backpressure on the input only comes from a stalled output
    `GPFT_ASSERT_NOW(a_ready_cause, clk, rst_n, !req_ready, rsp_valid && !rsp_ready)

    // once the quiet counter saturates with the receiver ready, the pipeline has drained
    `GPFT_ASSERT_NOW(a_drain, clk, rst_n, quiet_cnt_reg == 3'd5, !rsp_valid)

endmodule

bind gaussian_point_frame_transform_unit gpft_checker u_gpft_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
);

`default_nettype wire

>>> bench/tb_gaussian_point_frame_transform_unit.sv
// testbench for the gaussian point frame transform unit with a built-in transform predictor
`default_nettype none

module tb_gaussian_point_frame_transform_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NFRAMES = 16;
    localparam int FRAC    = 16;
    localparam longint ONE = 64'sd1 << FRAC;
    localparam int NUM_RANDOM = 1100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    gpft_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    gpft_pkg::rsp_t rsp;

    gaussian_point_frame_transform_unit #(.NUM_FRAMES(NFRAMES), .FRAC_BITS(FRAC)) dut (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_ready(req_ready),
        .req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    always #5 clk = ~clk;

    initial
    begin
        #20ms;
        $display("gaussian_point_frame_transform_unit test failed");
        $finish;
    end

    logic [31:0] frame_words [NFRAMES*gpft_pkg::WORDS_PER_FRAME];
    gpft_pkg::rsp_t expected_points [$];
    int errors = 0;
    bit stim_done = 1'b0;
    bit hold_off = 1'b0;

    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b + (64'sd1 << (FRAC - 1));
        return p >>> FRAC;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic longint sx(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    // updates the frame table on loads, returns 1 with the predicted point on transforms
    function automatic bit transform_point(gpft_pkg::req_t r, output gpft_pkg::rsp_t e);
        longint tv [3], sp [3], m [3][3], p [3];
        longint qx, qy, qz, qw, s, xx, yy, zz, xy, xz, yz, xw, yw, zw, pw, px, py, pz;
        int b;
        e = '0;
        if (r.func == gpft_pkg::FUNC_LOAD)
        begin
            if (r.entry_addr / gpft_pkg::WORDS_PER_FRAME < NFRAMES)
                frame_words[r.entry_addr] = r.pos_x;
            return 1'b0;
        end
        if (r.entry_addr >= NFRAMES)
        begin
            e = {r.pos_x, r.pos_y, r.pos_z, r.quat_w, r.quat_x, r.quat_y, r.quat_z,
                 r.size_x, r.size_y, r.size_z, 1'b1};
            return 1'b1;
        end
        b = r.entry_addr * gpft_pkg::WORDS_PER_FRAME;
        for (int i = 0; i < 3; i++)
            tv[i] = sx(frame_words[b + i]);
        qx = sx(frame_words[b + 3]); qy = sx(frame_words[b + 4]);
        qz = sx(frame_words[b + 5]); qw = sx(frame_words[b + 6]);
        s = sx(frame_words[b + 7]);
        xx = qmul(qx, qx); yy = qmul(qy, qy); zz = qmul(qz, qz);
        xy = qmul(qx, qy); xz = qmul(qx, qz); yz = qmul(qy, qz);
        xw = qmul(qx, qw); yw = qmul(qy, qw); zw = qmul(qz, qw);
        m[0][0] = sx(clamp32(ONE - 2 * (yy + zz)));
        m[0][1] = sx(clamp32(2 * (xy - zw)));
        m[0][2] = sx(clamp32(2 * (xz + yw)));
        m[1][0] = sx(clamp32(2 * (xy + zw)));
        m[1][1] = sx(clamp32(ONE - 2 * (xx + zz)));
        m[1][2] = sx(clamp32(2 * (yz - xw)));
        m[2][0] = sx(clamp32(2 * (xz - yw)));
        m[2][1] = sx(clamp32(2 * (yz + xw)));
        m[2][2] = sx(clamp32(ONE - 2 * (xx + yy)));
        p[0] = sx(r.pos_x); p[1] = sx(r.pos_y); p[2] = sx(r.pos_z);
        for (int i = 0; i < 3; i++)
            sp[i] = sx(clamp32(qmul(s, p[i])));
        e.out_pos_x = clamp32(tv[0] + qmul(m[0][0], sp[0]) + qmul(m[0][1], sp[1])
                              + qmul(m[0][2], sp[2]));
        e.out_pos_y = clamp32(tv[1] + qmul(m[1][0], sp[0]) + qmul(m[1][1], sp[1])
                              + qmul(m[1][2], sp[2]));
        e.out_pos_z = clamp32(tv[2] + qmul(m[2][0], sp[0]) + qmul(m[2][1], sp[1])
                              + qmul(m[2][2], sp[2]));
        pw = sx(r.quat_w); px = sx(r.quat_x); py = sx(r.quat_y); pz = sx(r.quat_z);
        e.out_quat_w = clamp32(qmul(qw, pw) - qmul(qx, px) - qmul(qy, py) - qmul(qz, pz));
        e.out_quat_x = clamp32(qmul(qw, px) + qmul(qx, pw) + qmul(qy, pz) - qmul(qz, py));
        e.out_quat_y = clamp32(qmul(qw, py) - qmul(qx, pz) + qmul(qy, pw) + qmul(qz, px));
        e.out_quat_z = clamp32(qmul(qw, pz) + qmul(qx, py) - qmul(qy, px) + qmul(qz, pw));
        e.out_size_x = clamp32(qmul(sx(r.size_x), s));
        e.out_size_y = clamp32(qmul(sx(r.size_y), s));
        e.out_size_z = clamp32(qmul(sx(r.size_z), s));
        e.bad_frame = 1'b0;
        return 1'b1;
    endfunction

    // values biased toward extremes and small fixed-point numbers
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 2 * 65536) - 65536;
            3: return $urandom_range(0, 40 * 65536) - 20 * 65536;
            default: return $urandom;
        endcase
    endfunction

    function automatic gpft_pkg::req_t random_point();
        gpft_pkg::req_t r;
        r = '0;
        r.func = gpft_pkg::FUNC_XFORM;
        r.entry_addr = ($urandom_range(0, 9) == 0) ? 7'($urandom) :
                       7'($urandom_range(0, NFRAMES - 1));
        {r.pos_x, r.pos_y, r.pos_z} = {pick_value(), pick_value(), pick_value()};
        {r.quat_w, r.quat_x, r.quat_y, r.quat_z} =
            {pick_value(), pick_value(), pick_value(), pick_value()};
        {r.size_x, r.size_y, r.size_z} = {pick_value(), pick_value(), pick_value()};
        return r;
    endfunction

    function automatic gpft_pkg::req_t frame_load(int addr, logic [31:0] v);
        gpft_pkg::req_t r;
        r = random_point();
        r.func = gpft_pkg::FUNC_LOAD;
        r.entry_addr = 7'(addr);
        r.pos_x = v;
        return r;
    endfunction

    // valid stays high between back-to-back transactions
    task automatic send(gpft_pkg::req_t r);
        gpft_pkg::rsp_t e;
        int idle;
        idle = $urandom_range(0, 4);
        if (idle > 0)
        begin
            req_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!req_ready);
        if (transform_point(r, e))
            expected_points.push_back(e);
    endtask

    // directed rows: value typed in only where obvious, otherwise predicted
    typedef struct {
        gpft_pkg::req_t  r;
        bit              typed;
        gpft_pkg::rsp_t  e;
    } row_t;

    row_t rows [$];

    function automatic gpft_pkg::req_t point_of(int fr, logic [31:0] v);
        gpft_pkg::req_t r;
        r = '0;
        r.func = gpft_pkg::FUNC_XFORM;
        r.entry_addr = 7'(fr);
        {r.pos_x, r.pos_y, r.pos_z, r.quat_w, r.quat_x, r.quat_y, r.quat_z,
         r.size_x, r.size_y, r.size_z} = {10{v}};
        return r;
    endfunction

    task automatic build_rows();
        gpft_pkg::req_t r;
        gpft_pkg::rsp_t e;
        // identity frame after reset: point passes through
        r = point_of(0, 32'h0001_0000);
        e = {{10{32'h0001_0000}}, 1'b0};
        rows.push_back('{r, 1'b1, e});
        // out of range frames: unchanged with the flag
        r = point_of(NFRAMES, 32'h8000_0000);
        e = {{10{32'h8000_0000}}, 1'b1};
        rows.push_back('{r, 1'b1, e});
        r = point_of(127, 32'h7fff_ffff);
        e = {{10{32'h7fff_ffff}}, 1'b1};
        rows.push_back('{r, 1'b1, e});
        r = point_of(NFRAMES - 1, 32'h7fff_ffff);
        rows.push_back('{r, 1'b0, e});
        r = point_of(3, 32'h8000_0000);
        rows.push_back('{r, 1'b0, e});
        // load to the last word of the last frame
        rows.push_back('{frame_load(127, 32'h1234_5678), 1'b0, e});
        // frame 2: 90 degrees about z, scale 2, translation, then a saturating frame
        rows.push_back('{frame_load(16 + 0, 32'h0003_0000), 1'b0, e});
        rows.push_back('{frame_load(16 + 5, 32'h0000_b505), 1'b0, e});
        rows.push_back('{frame_load(16 + 6, 32'h0000_b505), 1'b0, e});
        rows.push_back('{frame_load(16 + 7, 32'h0002_0000), 1'b0, e});
        r = point_of(2, 32'h0001_0000);
        rows.push_back('{r, 1'b0, e});
        rows.push_back('{frame_load(NFRAMES * 8 - 8 + 3, 32'h7fff_ffff), 1'b0, e});
        rows.push_back('{frame_load(NFRAMES * 8 - 8 + 4, 32'h8000_0000), 1'b0, e});
        rows.push_back('{frame_load(NFRAMES * 8 - 1, 32'h7fff_ffff), 1'b0, e});
        r = point_of(NFRAMES - 1, 32'h7fff_ffff);
        rows.push_back('{r, 1'b0, e});
        r = point_of(NFRAMES - 1, 32'h8000_0000);
        rows.push_back('{r, 1'b0, e});
        r = point_of(NFRAMES - 1, 32'hffff_ffff);
        rows.push_back('{r, 1'b0, e});
    endtask

    initial
    begin
        int w, fr;
        gpft_pkg::rsp_t e;
        for (int f = 0; f < NFRAMES; f++)
            for (int k = 0; k < gpft_pkg::WORDS_PER_FRAME; k++)
                frame_words[f * gpft_pkg::WORDS_PER_FRAME + k] =
                    (k >= 6) ? 32'(ONE) : 32'h0;
        build_rows();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
        begin
            // typed rows are transforms only, so the table is untouched here
            if (rows[i].typed)
            begin
                void'(transform_point(rows[i].r, e));
                if (e !== rows[i].e)
                begin
                    $display("%0t directed row %0d: expected %h actual predictor %h",
                             $time, i, rows[i].e, e);
                    errors++;
                end
            end
            send(rows[i].r);
        end
        // random: frame loads in full sets, points, stray loads
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n == NUM_RANDOM / 2)
                hold_off = 1'b1;
            w = $urandom_range(0, 19);
            if (w < 2)
            begin
                fr = $urandom_range(0, NFRAMES - 1);
                for (int k = 0; k < gpft_pkg::WORDS_PER_FRAME; k++)
                    send(frame_load(fr * 8 + k, ($urandom_range(0, 3) == 0) ?
                         pick_value() : 32'($urandom_range(0, 2 * 65536)) - 65536));
            end
            else if (w < 3)
                send(frame_load($urandom_range(0, 127), pick_value()));
            else
                send(random_point());
        end
        req_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: idle cycles drawn per transaction plus one long hold-off
    initial
    begin
        int idle;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                hold_off = 1'b0;
                rsp_ready <= 1'b0;
                repeat (60) @(posedge clk);
            end
            idle = $urandom_range(0, 4);
            if (idle > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (idle) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
        end
    end

    always @(posedge clk)
    begin
        gpft_pkg::rsp_t e;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_points.size() == 0)
            begin
                $display("%0t unexpected point: expected none actual %h", $time, rsp);
                errors++;
            end
            else
            begin
                e = expected_points.pop_front();
                if (rsp.out_pos_x !== e.out_pos_x || rsp.out_pos_y !== e.out_pos_y ||
                    rsp.out_pos_z !== e.out_pos_z || rsp.out_quat_w !== e.out_quat_w ||
                    rsp.out_quat_x !== e.out_quat_x || rsp.out_quat_y !== e.out_quat_y ||
                    rsp.out_quat_z !== e.out_quat_z || rsp.out_size_x !== e.out_size_x ||
                    rsp.out_size_y !== e.out_size_y || rsp.out_size_z !== e.out_size_z ||
                    rsp.bad_frame !== e.bad_frame)
                begin
                    $display("%0t point mismatch: expected %h actual %h", $time, e, rsp);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        wait (stim_done);
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_points.size() == 0)
            $display("gaussian_point_frame_transform_unit test passed");
        else
            $display("gaussian_point_frame_transform_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/gpft_pkg.sv
rtl/gpft_ram.sv
rtl/gaussian_point_frame_transform_unit.sv
rtl/gpft_checker.sv
bench/tb_gaussian_point_frame_transform_unit.sv
